[rtl/simplex_tableau_pivot_top_assert.svh]
// Assertion macros shared by the tableau pivot RTL.
`ifndef SIMPLEX_TABLEAU_PIVOT_TOP_ASSERT_SVH
`define SIMPLEX_TABLEAU_PIVOT_TOP_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define STP_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("tableau pivot check failed");

// A consequence that holds in the same cycle as its cause.
`define STP_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tableau pivot check failed");

// A consequence that holds in the cycle after its cause.
`define STP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tableau pivot check failed");

`endif

[rtl/stp_pkg.sv]
package stp_pkg;

   localparam int MAX_ROWS_DEF  = 32;
   localparam int MAX_COLS_DEF  = 32;
   localparam int FRAC_BITS_DEF = 16;

   localparam int DATA_W    = 32;
   localparam int IDX_W     = 5;
   localparam int KIND_W    = 2;
   localparam int STAT_W    = 2;
   localparam int CSR_W     = 6;
   localparam int CSR_IDX_W = 1;

   // The quotient is kept to this many bits; anything larger saturates anyway.
   localparam int QUO_W = 34;
   localparam int DIV_W = 66;

   localparam logic [CSR_W-1:0] CSR_COUNT_RESET = 6'd32;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 1'd1;

   typedef enum logic [KIND_W-1:0] {
      REQ_WRITE  = 2'd0,
      REQ_READ   = 2'd1,
      REQ_PIVOT  = 2'd2,
      REQ_UNUSED = 2'd3
   } req_kind_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_ZERO  = 2'd1,
      STAT_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      logic             vld;
      logic             ovf;
      logic             sgn;
      logic [QUO_W-1:0] mag;
   } div_res_type;

endpackage

[rtl/stp_req_if.sv]
interface stp_req_if;
   logic                                valid;
   logic                                ready;
   logic [stp_pkg::KIND_W-1:0]          req_type;
   logic [stp_pkg::IDX_W-1:0]           row_idx;
   logic [stp_pkg::IDX_W-1:0]           col_index;
   logic signed [stp_pkg::DATA_W-1:0]   write_value;

   modport source (output valid, req_type, row_idx, col_index, write_value, input ready);
   modport sink (input valid, req_type, row_idx, col_index, write_value, output ready);
endinterface

[rtl/stp_rsp_if.sv]
interface stp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [stp_pkg::DATA_W-1:0]   read_value;
   logic [stp_pkg::STAT_W-1:0]          status;

   modport source (output valid, read_value, status, input ready);
   modport sink (input valid, read_value, status, output ready);
endinterface

[rtl/stp_div.sv]
module stp_div #(
   parameter int TAG_W = 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_vld,
   input  logic signed [2*stp_pkg::DATA_W-1:0] num,
   input  logic signed [stp_pkg::DATA_W-1:0] den,
   input  logic [TAG_W-1:0]                  in_tag,
   output stp_pkg::div_res_type              res,
   output logic [TAG_W-1:0]                  out_tag
);

   localparam int NW = 2 * stp_pkg::DATA_W;
   localparam int DW = stp_pkg::DIV_W;
   localparam int QW = stp_pkg::QUO_W;
   localparam int XW = stp_pkg::DATA_W;

   logic [DW-1:0] num_ext;
   logic [DW-1:0] num_mag;
   logic [DW-1:0] den_ext;
   logic [DW-1:0] den_mag;

   logic [QW:0]       vld_ff;
   logic [DW-1:0]     rem_ff [QW+1];
   logic [DW-1:0]     rem_in [QW+1];
   logic [QW-1:0]     quo_ff [QW+1];
   logic [QW-1:0]     quo_in [QW+1];
   logic [QW:0]       ovf_ff;
   logic [QW:0]       sgn_ff;
   logic [TAG_W-1:0]  tag_ff [QW+1];

   assign num_ext = {{(DW-NW){num[NW-1]}}, num};
   assign num_mag = num_ext[DW-1] ? (~num_ext + DW'(1)) : num_ext;
   assign den_ext = {{(DW-XW){den[XW-1]}}, den};
   assign den_mag = den_ext[DW-1] ? (~den_ext + DW'(1)) : den_ext;

   always_comb begin
      logic [DW-1:0] trial;
      trial = '0;
      rem_in[0] = num_mag;
      quo_in[0] = '0;
      for (int k = 1; k <= QW; k++) begin
         trial = den_mag << (QW - k);
         rem_in[k] = rem_ff[k-1];
         quo_in[k] = quo_ff[k-1];
         if (rem_ff[k-1] >= trial) begin
            rem_in[k] = rem_ff[k-1] - trial;
            quo_in[k][QW-k] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[QW-1:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      ovf_ff[0] <= num_mag >= (den_mag << QW);
      sgn_ff[0] <= num[NW-1] ^ den[XW-1];
      tag_ff[0] <= in_tag;
      for (int k = 0; k <= QW; k++) begin
         rem_ff[k] <= rem_in[k];
         quo_ff[k] <= quo_in[k];
      end
      for (int k = 1; k <= QW; k++) begin
         ovf_ff[k] <= ovf_ff[k-1];
         sgn_ff[k] <= sgn_ff[k-1];
         tag_ff[k] <= tag_ff[k-1];
      end
   end

   assign res.vld = vld_ff[QW];
   assign res.ovf = ovf_ff[QW];
   assign res.sgn = sgn_ff[QW];
   assign res.mag = quo_ff[QW];
   assign out_tag = tag_ff[QW];

endmodule

[rtl/simplex_tableau_pivot_top.sv]
// Simplex tableau pivot engine over signed fixed-point entries.
// Requests arrive on req_chan (valid/ready) and each one yields exactly one
// response on rsp_chan: a write, a read, or a pivot on (row_idx, col_index).
// Register 0 sets the active rows and register 1 the active columns through
// the csr_ write port; write them only while no request is in flight.
// A write or a rejected request goes from idle straight to done; a read
// first passes the check state. In a pivot, the tableau memory read port
// loads the pivot row and column, then streams one entry per cycle through
// a multiplier and a 35-stage divider pipeline that writes each result back.
// One request is worked on at a time.
// Reset sets both counts to 32 and empties the response path; the tableau is
// not cleared, and an entry must be written before it is read or used.
// While the receiver stalls, the response stays in its output register, one
// more finished response waits inside, and no new request is taken until the
// waiting one moves to the output.
`include "simplex_tableau_pivot_top_assert.svh"

module simplex_tableau_pivot_top #(
   parameter int MAX_ROWS  = stp_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS  = stp_pkg::MAX_COLS_DEF,
   parameter int FRAC_BITS = stp_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   stp_req_if.sink                        req_chan,
   stp_rsp_if.source                      rsp_chan,
   input  logic                           csr_write_en,
   input  logic [stp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [stp_pkg::CSR_W-1:0]      csr_write_data
);

   localparam int DW    = stp_pkg::DATA_W;
   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NRW   = ($clog2(MAX_ROWS + 1) > stp_pkg::CSR_W) ?
                          $clog2(MAX_ROWS + 1) : stp_pkg::CSR_W;
   localparam int NCW   = ($clog2(MAX_COLS + 1) > stp_pkg::CSR_W) ?
                          $clog2(MAX_COLS + 1) : stp_pkg::CSR_W;
   localparam int TAG_W = 2 + DW + AW;
   localparam int SUM_W = stp_pkg::QUO_W + 2;
   localparam logic [DW-1:0] ONE_FIX = DW'(64'd1 << FRAC_BITS);
   localparam logic [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b00000001,
      ST_CHECK  = 8'b00000010,
      ST_LOADR  = 8'b00000100,
      ST_LOADC  = 8'b00001000,
      ST_GAP    = 8'b00010000,
      ST_UPDATE = 8'b00100000,
      ST_DRAIN  = 8'b01000000,
      ST_DONE   = 8'b10000000
   } state_type;

   function automatic logic [AW-1:0] entry_addr(input logic [RW-1:0] r,
                                                input logic [CW-1:0] c);
      entry_addr = AW'(r) * AW'(MAX_COLS) + AW'(c);
   endfunction

   state_type state_ff, state_in;

   logic [stp_pkg::CSR_W-1:0] rows_csr_ff, cols_csr_ff;
   logic [NRW-1:0] nr;
   logic [NCW-1:0] nc;

   logic [RW-1:0] pr_ff, pr_in, i_ff, i_in;
   logic [CW-1:0] pc_ff, pc_in, j_ff, j_in;
   logic [DW-1:0] alpha_ff, alpha_in;
   logic          is_pivot_ff, is_pivot_in;
   logic [DW-1:0] res_val_ff, res_val_in;
   stp_pkg::status_type res_stat_ff, res_stat_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_val_ff;
   logic [stp_pkg::STAT_W-1:0] rsp_stat_ff;
   logic          rsp_load;

   logic          req_accept;
   logic          in_range;
   logic [RW-1:0] req_r;
   logic [CW-1:0] req_c;
   logic          col_last, row_last;

   logic [DW-1:0] tableau_mem [DEPTH];
   logic [AW-1:0] rd_addr;
   logic [DW-1:0] mem_rd_ff;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [DW-1:0] mem_wd;

   logic [DW-1:0] row_buf [MAX_COLS];
   logic [DW-1:0] col_buf [MAX_ROWS];
   logic [DW-1:0] beta_ff, gamma_ff;
   logic          ld_row_ff, ld_col_ff;

   logic          s1_vld_ff, s1_last_ff;
   logic [RW-1:0] s1_i_ff;
   logic [CW-1:0] s1_j_ff;
   logic [AW-1:0] s1_addr_ff;
   logic signed [DW-1:0] op_a, op_b;
   logic [DW-1:0] op_delta;
   logic          op_neg;

   logic          s2_vld_ff, s2_last_ff, s2_neg_ff;
   logic [DW-1:0] s2_delta_ff;
   logic [AW-1:0] s2_addr_ff;
   logic signed [2*DW-1:0] prod_ff;

   stp_pkg::div_res_type div_res;
   logic [TAG_W-1:0] div_tag;
   logic          wb_last, wb_neg, wb_sgn;
   logic [DW-1:0] wb_delta;
   logic [AW-1:0] wb_addr;
   logic [SUM_W-1:0] wb_q, wb_sum;
   logic [DW-1:0] wb_val;

   assign nr = (NRW'(rows_csr_ff) > NRW'(MAX_ROWS)) ? NRW'(MAX_ROWS) : NRW'(rows_csr_ff);
   assign nc = (NCW'(cols_csr_ff) > NCW'(MAX_COLS)) ? NCW'(MAX_COLS) : NCW'(cols_csr_ff);

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept = req_chan.valid && req_chan.ready;
   assign req_r = RW'(req_chan.row_idx);
   assign req_c = CW'(req_chan.col_index);
   assign in_range = (req_chan.req_type != stp_pkg::REQ_UNUSED) &&
                     (NRW'(req_chan.row_idx) < nr) &&
                     (NCW'(req_chan.col_index) < nc);

   assign col_last = (NCW'(j_ff) == nc - NCW'(1));
   assign row_last = (NRW'(i_ff) == nr - NRW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_csr_ff <= stp_pkg::CSR_COUNT_RESET;
         cols_csr_ff <= stp_pkg::CSR_COUNT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            stp_pkg::CSR_ROWS: rows_csr_ff <= csr_write_data;
            stp_pkg::CSR_COLS: cols_csr_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in    = state_ff;
      pr_in       = pr_ff;
      pc_in       = pc_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      alpha_in    = alpha_ff;
      is_pivot_in = is_pivot_ff;
      res_val_in  = res_val_ff;
      res_stat_in = res_stat_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               pr_in       = req_r;
               pc_in       = req_c;
               res_val_in  = '0;
               res_stat_in = stp_pkg::STAT_OK;
               if (!in_range) begin
                  res_stat_in = stp_pkg::STAT_RANGE;
                  state_in    = ST_DONE;
               end else begin
                  unique case (req_chan.req_type)
                     stp_pkg::REQ_WRITE: state_in = ST_DONE;
                     stp_pkg::REQ_READ: begin
                        is_pivot_in = 1'b0;
                        state_in    = ST_CHECK;
                     end
                     default: begin
                        is_pivot_in = 1'b1;
                        state_in    = ST_CHECK;
                     end
                  endcase
               end
            end
         end
         ST_CHECK: begin
            if (!is_pivot_ff) begin
               res_val_in = mem_rd_ff;
               state_in   = ST_DONE;
            end else if (mem_rd_ff == '0) begin
               res_stat_in = stp_pkg::STAT_ZERO;
               state_in    = ST_DONE;
            end else begin
               alpha_in = mem_rd_ff;
               i_in     = '0;
               j_in     = '0;
               state_in = ST_LOADR;
            end
         end
         ST_LOADR: begin
            j_in = j_ff + CW'(1);
            if (col_last) begin
               j_in     = '0;
               state_in = ST_LOADC;
            end
         end
         ST_LOADC: begin
            i_in = i_ff + RW'(1);
            if (row_last) begin
               i_in     = '0;
               state_in = ST_GAP;
            end
         end
         ST_GAP: state_in = ST_UPDATE;
         ST_UPDATE: begin
            j_in = j_ff + CW'(1);
            if (col_last) begin
               j_in = '0;
               i_in = i_ff + RW'(1);
               if (row_last) begin
                  i_in     = '0;
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (div_res.vld && wb_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      pr_ff       <= pr_in;
      pc_ff       <= pc_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      alpha_ff    <= alpha_in;
      is_pivot_ff <= is_pivot_in;
      res_val_ff  <= res_val_in;
      res_stat_ff <= res_stat_in;
   end

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_val_ff  <= res_val_ff;
         rsp_stat_ff <= res_stat_ff;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_value = rsp_val_ff;
   assign rsp_chan.status     = rsp_stat_ff;

   always_comb begin
      unique case (state_ff)
         ST_IDLE:   rd_addr = entry_addr(req_r, req_c);
         ST_LOADR:  rd_addr = entry_addr(pr_ff, j_ff);
         ST_LOADC:  rd_addr = entry_addr(i_ff, pc_ff);
         ST_UPDATE: rd_addr = entry_addr(i_ff, j_ff);
         default:   rd_addr = '0;
      endcase
   end

   always_comb begin
      if (req_accept && in_range && (req_chan.req_type == stp_pkg::REQ_WRITE)) begin
         mem_we = 1'b1;
         mem_wa = entry_addr(req_r, req_c);
         mem_wd = req_chan.write_value;
      end else begin
         mem_we = div_res.vld;
         mem_wa = wb_addr;
         mem_wd = wb_val;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tableau_mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= tableau_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ld_row_ff  <= 1'b0;
         ld_col_ff  <= 1'b0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
      end else begin
         ld_row_ff  <= (state_ff == ST_LOADR);
         ld_col_ff  <= (state_ff == ST_LOADC);
         s1_vld_ff  <= (state_ff == ST_UPDATE);
         s2_vld_ff  <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff <= (state_ff == ST_UPDATE) && col_last && row_last;
      s1_i_ff    <= i_ff;
      s1_j_ff    <= j_ff;
      s1_addr_ff <= rd_addr;
      if (ld_row_ff) begin
         row_buf[s1_j_ff] <= mem_rd_ff;
      end
      if (ld_col_ff) begin
         col_buf[s1_i_ff] <= mem_rd_ff;
      end
      beta_ff  <= row_buf[j_ff];
      gamma_ff <= col_buf[i_ff];
   end

   always_comb begin
      unique case ({s1_i_ff == pr_ff, s1_j_ff == pc_ff})
         2'b00: begin
            op_a = beta_ff;
            op_b = gamma_ff;
            op_delta = mem_rd_ff;
            op_neg = 1'b1;
         end
         2'b10: begin
            op_a = beta_ff;
            op_b = ONE_FIX;
            op_delta = '0;
            op_neg = 1'b1;
         end
         2'b01: begin
            op_a = gamma_ff;
            op_b = ONE_FIX;
            op_delta = '0;
            op_neg = 1'b0;
         end
         default: begin
            op_a = ONE_FIX;
            op_b = ONE_FIX;
            op_delta = '0;
            op_neg = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff     <= op_a * op_b;
      s2_last_ff  <= s1_last_ff;
      s2_neg_ff   <= op_neg;
      s2_delta_ff <= op_delta;
      s2_addr_ff  <= s1_addr_ff;
   end

   stp_div #(
      .TAG_W(TAG_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (s2_vld_ff),
      .num     (prod_ff),
      .den     (alpha_ff),
      .in_tag  ({s2_last_ff, s2_neg_ff, s2_delta_ff, s2_addr_ff}),
      .res     (div_res),
      .out_tag (div_tag)
   );

   assign {wb_last, wb_neg, wb_delta, wb_addr} = div_tag;
   assign wb_sgn = div_res.sgn ^ wb_neg;
   assign wb_q   = wb_sgn ? (~{2'b00, div_res.mag} + SUM_W'(1)) : {2'b00, div_res.mag};
   assign wb_sum = {{(SUM_W-DW){wb_delta[DW-1]}}, wb_delta} + wb_q;

   always_comb begin
      if (div_res.ovf) begin
         wb_val = wb_sgn ? SAT_MIN : SAT_MAX;
      end else if ((wb_sum[SUM_W-1:DW-1] != '0) && (wb_sum[SUM_W-1:DW-1] != '1)) begin
         wb_val = wb_sum[SUM_W-1] ? SAT_MIN : SAT_MAX;
      end else begin
         wb_val = wb_sum[DW-1:0];
      end
   end

   `STP_ASSERT_ALWAYS(a_state_onehot, $onehot(state_ff))
   `STP_ASSERT_SAME(a_wb_only_in_pivot, div_res.vld, (state_ff == ST_UPDATE) || (state_ff == ST_DRAIN))
   `STP_ASSERT_SAME(a_reject_no_write, req_accept && !in_range, !mem_we)
   `STP_ASSERT_NEXT(a_zero_pivot_done, (state_ff == ST_CHECK) && is_pivot_ff && (mem_rd_ff == '0), (state_ff == ST_DONE) && !mem_we && (res_stat_ff == stp_pkg::STAT_ZERO))

endmodule
